[rtl/core/ipllc_pkg.sv]
// Shared types, constants and character-class helpers for the line classifier.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package ipllc_pkg;

  // Sizing
  localparam int LINE_MAX_BYTES = 1024;
  localparam int TOKEN_MAX      = 256;
  localparam int POS_W          = $clog2(LINE_MAX_BYTES + 1);
  localparam int LEN_W          = $clog2(TOKEN_MAX + 1);
  localparam int OFS_FW         = 10;  // offset field width
  localparam int LEN_FW         = 9;   // length field width

  // Line kinds
  localparam logic [2:0] KIND_EMPTY   = 3'd0;
  localparam logic [2:0] KIND_ONE     = 3'd1;
  localparam logic [2:0] KIND_RANGE   = 3'd2;
  localparam logic [2:0] KIND_HOST    = 3'd3;
  localparam logic [2:0] KIND_INVALID = 3'd4;

  // Families
  localparam logic [1:0] FAM_UNKNOWN = 2'd0;
  localparam logic [1:0] FAM_V4      = 2'd1;
  localparam logic [1:0] FAM_V6      = 2'd2;

  // Scan phases
  localparam logic [3:0] PH_LEAD        = 4'd0;
  localparam logic [3:0] PH_ADDR        = 4'd1;
  localparam logic [3:0] PH_ADDR_TAIL   = 4'd2;
  localparam logic [3:0] PH_HOST        = 4'd3;
  localparam logic [3:0] PH_DASH        = 4'd4;
  localparam logic [3:0] PH_SECOND      = 4'd5;
  localparam logic [3:0] PH_SECOND_TAIL = 4'd6;
  localparam logic [3:0] PH_EMPTY       = 4'd8;
  localparam logic [3:0] PH_ONE         = 4'd9;
  localparam logic [3:0] PH_TWO         = 4'd10;
  localparam logic [3:0] PH_HOSTNAME    = 4'd11;
  localparam logic [3:0] PH_INVALID     = 4'd12;

  // Hostname run phases
  localparam logic [1:0] HP_IDLE = 2'd0;
  localparam logic [1:0] HP_RUN  = 2'd1;
  localparam logic [1:0] HP_TAIL = 2'd2;
  localparam logic [1:0] HP_DEAD = 2'd3;

  // Token flag bits
  localparam int FL_COLON  = 0;
  localparam int FL_DOT    = 1;
  localparam int FL_SLASH  = 2;
  localparam int FL_DIGITS = 3;
  localparam logic [3:0] FLAGS_RESET = 4'b1000;

  // Characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  typedef struct packed {
    logic [1:0]       hp;
    logic [LEN_W-1:0] len;
  } host_t;

  typedef struct packed {
    logic [2:0]        line_kind;
    logic [OFS_FW-1:0] first_start;
    logic [LEN_FW-1:0] first_len;
    logic [OFS_FW-1:0] second_start;
    logic [LEN_FW-1:0] second_len;
    logic [1:0]        first_family;
    logic [1:0]        second_family;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_SEMI) || (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_addr_char(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))
        || (c == CH_COLON) || (c == CH_DOT) || (c == CH_SLASH);
  endfunction

  function automatic logic is_host_char(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
        || (c == CH_UNDER) || (c == CH_DASH) || (c == CH_DOT);
  endfunction

  function automatic logic [3:0] flags_add(input logic [3:0] f, input logic [7:0] c);
    logic [3:0] r;
    r = f;
    if (c == CH_COLON) r[FL_COLON] = 1'b1;
    if (c == CH_DOT)   r[FL_DOT]   = 1'b1;
    if (c == CH_SLASH) r[FL_SLASH] = 1'b1;
    if (!is_digit(c))  r[FL_DIGITS] = 1'b0;
    return r;
  endfunction

  function automatic logic [1:0] family_of(input logic [3:0] f);
    if (f[FL_COLON]) return FAM_V6;
    if (f[FL_DOT] || f[FL_SLASH] || f[FL_DIGITS]) return FAM_V4;
    return FAM_UNKNOWN;
  endfunction

  // One byte into the hostname run; terminators never get here.
  function automatic host_t host_feed(input logic [1:0] hp, input logic [LEN_W-1:0] len,
                                      input logic [7:0] c);
    host_t r;
    r.hp  = hp;
    r.len = len;
    if (hp == HP_RUN) begin
      if (is_host_char(c)) begin
        if (len >= LEN_W'(TOKEN_MAX)) r.hp = HP_DEAD;
        else r.len = len + LEN_W'(1);
      end else if (is_blank(c)) begin
        r.hp = HP_TAIL;
      end else begin
        r.hp = HP_DEAD;
      end
    end else if (hp == HP_TAIL) begin
      if (!is_blank(c)) r.hp = HP_DEAD;
    end
    return r;
  endfunction

endpackage

[rtl/core/ipllc_if.sv]
// Valid/ready channel interfaces: line bytes in, line results out.
// Depends on ipllc_pkg for field widths.
`timescale 1ns / 1ps

interface ipllc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, ch, line_end, input ready);
  modport sink   (input valid, ch, line_end, output ready);
endinterface

interface ipllc_res_if
  import ipllc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        line_kind;
  logic [OFS_FW-1:0] first_start;
  logic [LEN_FW-1:0] first_len;
  logic [OFS_FW-1:0] second_start;
  logic [LEN_FW-1:0] second_len;
  logic [1:0]        first_family;
  logic [1:0]        second_family;

  modport source (output valid, line_kind, first_start, first_len, second_start, second_len,
                  first_family, second_family, input ready);
  modport sink   (input valid, line_kind, first_start, first_len, second_start, second_len,
                  first_family, second_family, output ready);
endinterface

[rtl/core/ipllc_scan.sv]
// Per-byte scanner: phase, run counters and flags, plus the line result on the last byte.
// Depends on ipllc_pkg.
`timescale 1ns / 1ps

module ipllc_scan
  import ipllc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       line_end,
  output logic       res_vld,
  output res_t       res
);

  logic [3:0]       phase, phase_next, phase_fin;
  logic [1:0]       host_phase, host_phase_next;
  logic [POS_W-1:0] position, position_next;
  logic [LEN_W-1:0] addr_run_len, addr_run_len_next;
  logic [LEN_W-1:0] host_run_len, host_run_len_next;
  logic [OFS_FW-1:0] token_start, token_start_next;
  logic [OFS_FW-1:0] range_start, range_start_next;
  logic [LEN_W-1:0] range_len, range_len_next;
  logic [3:0]       first_flags, first_flags_next;
  logic [3:0]       range_flags, range_flags_next;
  host_t            hf, hf_lead;

  assign hf      = host_feed(host_phase, host_run_len, ch);
  assign hf_lead = host_feed(HP_RUN, '0, ch);

  always_comb begin
    phase_next        = phase;
    host_phase_next   = host_phase;
    position_next     = position;
    addr_run_len_next = addr_run_len;
    host_run_len_next = host_run_len;
    token_start_next  = token_start;
    range_start_next  = range_start;
    range_len_next    = range_len;
    first_flags_next  = first_flags;
    range_flags_next  = range_flags;

    if (phase < PH_EMPTY) begin
      if (position >= POS_W'(LINE_MAX_BYTES)) begin
        phase_next = PH_INVALID;
      end else begin
        position_next = position + POS_W'(1);
        unique case (phase)
          PH_LEAD: begin
            if (is_blank(ch)) begin
              phase_next = PH_LEAD;
            end else if (is_term(ch)) begin
              phase_next = PH_EMPTY;
            end else begin
              token_start_next  = position[OFS_FW-1:0];
              host_phase_next   = hf_lead.hp;
              host_run_len_next = hf_lead.len;
              if (is_addr_char(ch)) begin
                phase_next        = PH_ADDR;
                addr_run_len_next = LEN_W'(1);
                first_flags_next  = flags_add(first_flags, ch);
              end else if (is_host_char(ch)) begin
                phase_next = PH_HOST;
              end else begin
                phase_next = PH_INVALID;
              end
            end
          end
          PH_ADDR, PH_ADDR_TAIL: begin
            if (is_term(ch)) begin
              phase_next = PH_ONE;
            end else if (phase == PH_ADDR && is_addr_char(ch)) begin
              if (addr_run_len >= LEN_W'(TOKEN_MAX)) begin
                phase_next = PH_INVALID;
              end else begin
                addr_run_len_next = addr_run_len + LEN_W'(1);
                first_flags_next  = flags_add(first_flags, ch);
                host_phase_next   = hf.hp;
                host_run_len_next = hf.len;
              end
            end else if (is_blank(ch)) begin
              host_phase_next   = hf.hp;
              host_run_len_next = hf.len;
              phase_next        = PH_ADDR_TAIL;
            end else if (ch == CH_DASH) begin
              phase_next = PH_DASH;
            end else begin
              // not an address after all: retry as a hostname if plain letters
              host_phase_next   = hf.hp;
              host_run_len_next = hf.len;
              if (first_flags == 4'b0000 && hf.hp != HP_DEAD) phase_next = PH_HOST;
              else phase_next = PH_INVALID;
            end
          end
          PH_HOST: begin
            if (is_term(ch)) begin
              phase_next = PH_HOSTNAME;
            end else begin
              host_phase_next   = hf.hp;
              host_run_len_next = hf.len;
              if (hf.hp == HP_DEAD) phase_next = PH_INVALID;
            end
          end
          PH_DASH: begin
            if (is_blank(ch)) begin
              phase_next = PH_DASH;
            end else if (is_term(ch)) begin
              phase_next = PH_ONE;
            end else if (is_addr_char(ch)) begin
              phase_next       = PH_SECOND;
              range_start_next = position[OFS_FW-1:0];
              range_len_next   = LEN_W'(1);
              range_flags_next = flags_add(range_flags, ch);
            end else begin
              phase_next = PH_INVALID;
            end
          end
          PH_SECOND: begin
            if (is_term(ch)) begin
              phase_next = PH_TWO;
            end else if (is_addr_char(ch)) begin
              if (range_len >= LEN_W'(TOKEN_MAX)) begin
                phase_next = PH_INVALID;
              end else begin
                range_len_next   = range_len + LEN_W'(1);
                range_flags_next = flags_add(range_flags, ch);
              end
            end else if (is_blank(ch)) begin
              phase_next = PH_SECOND_TAIL;
            end else begin
              phase_next = PH_INVALID;
            end
          end
          PH_SECOND_TAIL: begin
            if (is_blank(ch)) phase_next = PH_SECOND_TAIL;
            else if (is_term(ch)) phase_next = PH_TWO;
            else phase_next = PH_INVALID;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // End of line acts as one more terminator.
  always_comb begin
    unique case (phase_next)
      PH_LEAD:                     phase_fin = PH_EMPTY;
      PH_ADDR, PH_ADDR_TAIL,
      PH_DASH:                     phase_fin = PH_ONE;
      PH_HOST:                     phase_fin = PH_HOSTNAME;
      PH_SECOND, PH_SECOND_TAIL:   phase_fin = PH_TWO;
      default:                     phase_fin = phase_next;
    endcase
  end

  always_comb begin
    res = '0;
    if (phase_fin == PH_ONE || phase_fin == PH_TWO) begin
      res.line_kind    = (phase_fin == PH_ONE) ? KIND_ONE : KIND_RANGE;
      res.first_start  = token_start_next;
      res.first_len    = LEN_FW'(addr_run_len_next);
      res.first_family = family_of(first_flags_next);
      if (phase_fin == PH_TWO) begin
        res.second_start  = range_start_next;
        res.second_len    = LEN_FW'(range_len_next);
        res.second_family = family_of(range_flags_next);
      end
    end else if (phase_fin == PH_HOSTNAME) begin
      res.line_kind   = KIND_HOST;
      res.first_start = token_start_next;
      res.first_len   = LEN_FW'(host_run_len_next);
    end else if (phase_fin == PH_INVALID) begin
      res.line_kind = KIND_INVALID;
    end
  end

  assign res_vld = take && line_end;

  always_ff @(posedge clk) begin
    if (rst || res_vld) begin
      phase        <= PH_LEAD;
      host_phase   <= HP_IDLE;
      position     <= '0;
      addr_run_len <= '0;
      host_run_len <= '0;
      token_start  <= '0;
      range_start  <= '0;
      range_len    <= '0;
      first_flags  <= FLAGS_RESET;
      range_flags  <= FLAGS_RESET;
    end else if (take) begin
      phase        <= phase_next;
      host_phase   <= host_phase_next;
      position     <= position_next;
      addr_run_len <= addr_run_len_next;
      host_run_len <= host_run_len_next;
      token_start  <= token_start_next;
      range_start  <= range_start_next;
      range_len    <= range_len_next;
      first_flags  <= first_flags_next;
      range_flags  <= range_flags_next;
    end
  end

endmodule

[rtl/core/ip_list_line_classifier_unit.sv]
// Top level of the address-list line classifier: scanner plus output register and skid word.
// Depends on ipllc_pkg, ipllc_if.sv (channel interfaces) and ipllc_scan.
//
// Usage:
//   bytes  : one word per line byte (ch), line_end set on the last byte of the line.
//   result : one word per line, produced only for the word carrying line_end:
//            line_kind, token offsets/lengths and address families.
// Throughput: one byte word per cycle while bytes.ready is high; the scanner state updates in the
//   same cycle the word is accepted.
// Result: the result word is registered into the output register, or into the skid word while that is held.
// Stall: the result sits in an output register; a second result can land in a one-word
//   skid register, so bytes keep flowing while the sink stalls. bytes.ready drops only
//   when the skid word is occupied, and rises again when the sink takes a word.
// Reset (rst, synchronous): scanner returns to start-of-line, both output words are
//   emptied. The scanner also returns to start-of-line after every line_end word.
`timescale 1ns / 1ps

module ip_list_line_classifier_unit
  import ipllc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  ipllc_byte_if.sink  bytes,
  ipllc_res_if.source result
);

  logic take;
  logic push;
  logic pop;
  res_t new_res;

  // Output register and skid word
  logic out_vld;
  logic skd_vld;
  res_t out_data;
  res_t skd_data;

  assign bytes.ready = !skd_vld;
  assign take        = bytes.valid && bytes.ready;
  assign pop         = out_vld && result.ready;

  ipllc_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .ch       (bytes.ch),
    .line_end (bytes.line_end),
    .res_vld  (push),
    .res      (new_res)
  );

  // Skid only fills when the output word is held and a new result arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      skd_vld <= 1'b0;
    end else if (pop) begin
      if (skd_vld) begin
        out_vld <= 1'b1;
        skd_vld <= 1'b0;
      end else begin
        out_vld <= push;
      end
    end else if (push) begin
      if (out_vld) skd_vld <= 1'b1;
      else out_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skd_vld) begin
      out_data <= skd_data;
    end else if (push && (pop || !out_vld)) begin
      out_data <= new_res;
    end
    if (push && out_vld && !pop) begin
      skd_data <= new_res;
    end
  end

  assign result.valid         = out_vld;
  assign result.line_kind     = out_data.line_kind;
  assign result.first_start   = out_data.first_start;
  assign result.first_len     = out_data.first_len;
  assign result.second_start  = out_data.second_start;
  assign result.second_len    = out_data.second_len;
  assign result.first_family  = out_data.first_family;
  assign result.second_family = out_data.second_family;

  // Skid word never holds data while the output word is empty.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skd_vld |-> out_vld)
    else $error("skid word occupied with empty output register");

  // After a line_end word is accepted, the output register holds a result in the next cycle.
  a_line_end_result: assert property (@(posedge clk) disable iff (rst)
    (bytes.valid && bytes.ready && bytes.line_end) |=> out_vld)
    else $error("line_end accepted but no result pending");

  // Empty and invalid lines carry no geometry.
  a_empty_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && (result.line_kind == KIND_EMPTY || result.line_kind == KIND_INVALID))
      |-> (result.first_start == '0 && result.first_len == '0
           && result.second_start == '0 && result.second_len == '0
           && result.first_family == FAM_UNKNOWN && result.second_family == FAM_UNKNOWN))
    else $error("empty or invalid line with nonzero fields");

  // Hostnames have no family and no second token.
  a_host_no_second: assert property (@(posedge clk) disable iff (rst)
    (out_vld && result.line_kind == KIND_HOST)
      |-> (result.first_family == FAM_UNKNOWN && result.second_len == '0
           && result.second_start == '0))
    else $error("hostname result with address fields");

endmodule
